/* sv/ebm_pkg.sv */
// Shared types, constants and default parameter values for the extent block mapper.
// No dependencies; every other file of the block imports this package.
package ebm_pkg;

    // Default parameter values
    localparam int unsigned MAX_EXTENTS_DEF     = 16;
    localparam int unsigned BLOCK_SIZE_BITS_DEF = 9;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_MAPPED     = 3'd0;
    localparam logic [2:0] ST_NEGATIVE   = 3'd1;
    localparam logic [2:0] ST_PAST_END   = 3'd2;
    localparam logic [2:0] ST_NO_EXTENT  = 3'd3;
    localparam logic [2:0] ST_WRITE_DONE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DISK_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_FILE_SIZE    = 2'd1;
    localparam logic [1:0] CFG_EXTENT_COUNT = 2'd2;

    // Request word
    typedef struct packed {
        logic               cmd;
        logic        [3:0]  entry_index;
        logic        [31:0] extent_disk_start;
        logic        [23:0] extent_file_start;
        logic        [7:0]  extent_length;
        logic signed [31:0] logical_block;
    } req_t;

    // Response word
    typedef struct packed {
        logic [31:0] disk_block;
        logic [2:0]  status;
    } rsp_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUNDS,
        S_SCAN,
        S_ADD_BASE,
        S_ADD_OFFS,
        S_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic bounds;
        logic scan_step;
        logic add_base;
        logic add_offs;
        logic push_out;
    } ebm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_map;
        logic negative;
        logic past_end;
        logic scan_empty;
        logic scan_hit;
        logic scan_miss_end;
        logic out_busy;
    } ebm_stat_t;

endpackage

/* sv/ebm_ctrl.sv */
// Controller state machine of the extent block mapper.
// Depends on ebm_pkg; drives ebm_dpath through ebm_cmd_t and reads ebm_stat_t.
module ebm_ctrl
    import ebm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  ebm_stat_t stat,
    output ebm_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.is_map ? S_BOUNDS : S_FINISH;
                end
            end
            S_BOUNDS:
            begin
                if (stat.negative || stat.past_end || stat.scan_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = S_ADD_BASE;
                end
                else if (stat.scan_miss_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ADD_BASE:
            begin
                state_next = S_ADD_OFFS;
            end
            S_ADD_OFFS:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Decode commands for the datapath
    always_comb
    begin
        req_stall     = (state_reg != S_IDLE);
        cmd.accept    = (state_reg == S_IDLE) && req_valid;
        cmd.bounds    = (state_reg == S_BOUNDS);
        cmd.scan_step = (state_reg == S_SCAN);
        cmd.add_base  = (state_reg == S_ADD_BASE);
        cmd.add_offs  = (state_reg == S_ADD_OFFS);
        cmd.push_out  = (state_reg == S_FINISH) && !stat.out_busy;
    end

endmodule

/* sv/ebm_dpath.sv */
// Datapath of the extent block mapper: configuration registers, extent memory,
// scan counters, result arithmetic and output register. Depends on ebm_pkg.
module ebm_dpath
    import ebm_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS     = MAX_EXTENTS_DEF,
    parameter int unsigned BLOCK_SIZE_BITS = BLOCK_SIZE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  req_t        req,
    output rsp_t        rsp,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  ebm_cmd_t    cmd,
    output ebm_stat_t   stat
);

    localparam int unsigned IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1);

    // Configuration state
    logic [31:0] disk_offset_reg;
    logic [4:0]  extent_count_reg;
    logic [31:0] last_blk_reg;
    logic        size_zero_reg;

    // Extent memory: {disk start, file start, length}
    logic [63:0] ext_mem [MAX_EXTENTS];
    logic [63:0] rd_data_reg;

    // Scan control
    logic [CNT_W-1:0] issue_cnt_reg;
    logic [CNT_W-1:0] cmp_cnt_reg;
    logic [CNT_W-1:0] limit_reg;
    logic             rd_valid_reg;

    // Working payload
    logic [31:0] blk_reg;
    logic [31:0] diff_reg;
    logic [31:0] base_reg;
    logic [31:0] acc_reg;
    logic [2:0]  res_status_reg;

    // Output register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic [8:0]       wr_ext;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [8:0]       cnt_ext;
    logic [8:0]       lim_ext;
    logic             issue;
    logic [31:0]      ent_disk;
    logic [23:0]      ent_file;
    logic [7:0]       ent_len;
    logic [24:0]      ent_end;
    logic             ent_hit;
    logic             cmp_last;

    // Slot write address and range check
    assign wr_ext  = {5'd0, req.entry_index};
    assign wr_en   = cmd.accept && (req.cmd == CMD_WRITE) && (wr_ext < 9'(MAX_EXTENTS));
    assign wr_addr = wr_ext[IDX_W-1:0];

    // Clip the scan length to the table depth
    assign cnt_ext = {4'd0, extent_count_reg};
    assign lim_ext = (cnt_ext > 9'(MAX_EXTENTS)) ? 9'(MAX_EXTENTS) : cnt_ext;

    // Compare the entry read in the previous cycle
    assign issue    = cmd.scan_step && (issue_cnt_reg < limit_reg);
    assign ent_disk = rd_data_reg[63:32];
    assign ent_file = rd_data_reg[31:8];
    assign ent_len  = rd_data_reg[7:0];
    assign ent_end  = {1'b0, ent_file} + {17'd0, ent_len};
    assign ent_hit  = (blk_reg >= {8'd0, ent_file}) && (blk_reg < {7'd0, ent_end});
    assign cmp_last = (cmp_cnt_reg == (limit_reg - CNT_W'(1)));

    // Configuration registers; bound of the file kept ready for the map check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_offset_reg  <= '0;
            extent_count_reg <= '0;
            last_blk_reg     <= '0;
            size_zero_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DISK_OFFSET:
                begin
                    disk_offset_reg <= cfg_data;
                end
                CFG_FILE_SIZE:
                begin
                    last_blk_reg  <= (cfg_data - 32'd1) >> BLOCK_SIZE_BITS;
                    size_zero_reg <= (cfg_data == 32'd0);
                end
                CFG_EXTENT_COUNT:
                begin
                    extent_count_reg <= cfg_data[4:0];
                end
                default:
                begin
                    disk_offset_reg <= disk_offset_reg;
                end
            endcase
        end
    end

    // Write and read the extent memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ext_mem[wr_addr] <= {req.extent_disk_start, req.extent_file_start,
                                 req.extent_length};
        end
        rd_data_reg <= ext_mem[issue_cnt_reg[IDX_W-1:0]];
    end

    // Advance the scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            cmp_cnt_reg   <= '0;
            limit_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else if (cmd.bounds)
        begin
            issue_cnt_reg <= '0;
            cmp_cnt_reg   <= '0;
            limit_reg     <= lim_ext[CNT_W-1:0];
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            if (cmd.scan_step && rd_valid_reg)
            begin
                cmp_cnt_reg <= cmp_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Latch the request, pick the result and build the mapped block
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            blk_reg        <= req.logical_block;
            acc_reg        <= '0;
            res_status_reg <= ST_WRITE_DONE;
        end
        if (cmd.bounds)
        begin
            if (blk_reg[31])
            begin
                res_status_reg <= ST_NEGATIVE;
            end
            else if (stat.past_end)
            begin
                res_status_reg <= ST_PAST_END;
            end
            else
            begin
                res_status_reg <= ST_NO_EXTENT;
            end
        end
        if (cmd.scan_step && rd_valid_reg && ent_hit)
        begin
            diff_reg <= blk_reg - {8'd0, ent_file};
            base_reg <= ent_disk;
        end
        if (cmd.add_base)
        begin
            acc_reg <= diff_reg + base_reg;
        end
        if (cmd.add_offs)
        begin
            acc_reg        <= acc_reg + disk_offset_reg;
            res_status_reg <= ST_MAPPED;
        end
        if (cmd.push_out)
        begin
            rsp_reg.disk_block <= acc_reg;
            rsp_reg.status     <= res_status_reg;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Report status to the controller
    always_comb
    begin
        stat.is_map        = (req.cmd == CMD_MAP);
        stat.negative      = blk_reg[31];
        stat.past_end      = size_zero_reg || (blk_reg > last_blk_reg);
        stat.scan_empty    = (lim_ext == 9'd0);
        stat.scan_hit      = rd_valid_reg && ent_hit;
        stat.scan_miss_end = rd_valid_reg && !ent_hit && cmp_last;
        stat.out_busy      = rsp_valid_reg && rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* sv/extent_block_mapper.sv */
// Top level of the extent block mapper: joins controller and datapath.
// Depends on ebm_pkg, ebm_ctrl and ebm_dpath.
//
//   channel   handshake              word
//   --------  ---------------------  --------------------------------------
//   req       req_valid / req_stall  req_t: write extent or map block
//   rsp       rsp_valid / rsp_stall  rsp_t: disk block and status
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A write goes straight to the finish state; a map checks its bounds, scans the
// table, and on a hit adds the extent base and then the disk offset. The scan
// issues one memory read per cycle. One word is in flight; a
// finished result waits in the output register while the next word is taken.
// Reset clears control and configuration; the extent table is not cleared.
// A stalled result holds the block in its finish state.
module extent_block_mapper
    import ebm_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS     = MAX_EXTENTS_DEF,
    parameter int unsigned BLOCK_SIZE_BITS = BLOCK_SIZE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp
);

    ebm_cmd_t  cmd;
    ebm_stat_t stat;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    ebm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ebm_dpath #(
        .MAX_EXTENTS     (MAX_EXTENTS),
        .BLOCK_SIZE_BITS (BLOCK_SIZE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* sv/ebm_checker.sv */
// Port-level checks for the extent block mapper, bound to the top level.
// Depends on ebm_pkg and extent_block_mapper.
module ebm_checker
    import ebm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A taken word closes the input until its work is done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous word still in flight");

    // Only a mapped result carries a disk block
    a_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_MAPPED) |-> rsp.disk_block == 32'd0)
        else $error("unmapped result with nonzero disk block");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ST_WRITE_DONE)
        else $error("undefined status code");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind extent_block_mapper ebm_checker u_ebm_checker (.*);
